>>> src/iac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_pkg
// Shared types and constants of the in-flight access coalescer.
// ----------------------------------------------------------------------------
package iac_pkg;

	localparam int DEFAULT_DEPTH = 16;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_FINISH = 2'd1;
	localparam logic [1:0] CMD_MARK   = 2'd2;
	localparam logic [1:0] CMD_PROBE  = 2'd3;

	localparam logic [1:0] KIND_LOAD     = 2'd0;
	localparam logic [1:0] KIND_STORE    = 2'd1;
	localparam logic [1:0] KIND_NCSTORE  = 2'd2;
	localparam logic [1:0] KIND_PREFETCH = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam logic CFG_BLOCK_SHIFT = 1'b0;
	localparam logic CFG_MISS_SLOTS  = 1'b1;

	typedef struct packed {
		logic load;
		logic apply;
	} iac_ctrl_t;

endpackage

>>> src/iac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_ctrl
// Two-state controller: captures a request, then lets the datapath apply it.
// ----------------------------------------------------------------------------
module iac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output iac_pkg::iac_ctrl_t ctrl
);
	import iac_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q == S_EXEC);
	assign ctrl.load = start && (state_q == S_IDLE);
	assign ctrl.apply = (state_q == S_EXEC);
endmodule

>>> src/iac_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_datapath
// Age-ordered slot table with parallel block and id compare.
// ----------------------------------------------------------------------------
module iac_datapath #(
	parameter int DEPTH = iac_pkg::DEFAULT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  iac_pkg::iac_ctrl_t ctrl,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic [1:0]         cmd,
	input  logic [31:0]        access_id,
	input  logic [31:0]        address,
	input  logic [1:0]         kind,
	output logic               done,
	output logic [1:0]         status,
	output logic               partner_found,
	output logic [31:0]        partner_id,
	output logic               id_in_flight,
	output logic               may_accept,
	output logic [$clog2(DEPTH+1)-1:0] occupancy
);
	import iac_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [3:0]    shift_q;
	logic [4:0]    slots_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] merged_q;
	logic [DEPTH-1:0] valid_q;
	logic [31:0]   id_q [DEPTH];
	logic [31:0]   blk_q [DEPTH];
	logic [1:0]    kind_q [DEPTH];
	logic          mrg_q [DEPTH];
	logic [31:0]   mst_q [DEPTH];
	logic          stt_q [DEPTH];

	logic [1:0]  cmd_q;
	logic [1:0]  kind_r_q;
	logic [31:0] aid_q;
	logic [31:0] addr_q;

	logic [DEPTH-1:0] same;
	logic [DEPTH-1:0] idm;
	logic [DEPTH-1:0] lp;
	logic             any_same;
	logic             fnd;
	logic [31:0]      pid;
	logic             hit;
	logic [IW-1:0]    hidx;
	logic [IW-1:0]    last;
	logic             lnot;
	logic             full;
	logic [CW-1:0]    n_next;
	logic [CW-1:0]    m_next;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			same[i] = valid_q[i] && ((blk_q[i] >> shift_q) == (addr_q >> shift_q));
			idm[i]  = valid_q[i] && (id_q[i] == aid_q);
			lp[i]   = (kind_q[i] == KIND_LOAD) || (kind_q[i] == KIND_PREFETCH);
		end
	end

	always_comb begin
		any_same = |same;
		fnd = 1'b0;
		pid = '0;
		lnot = 1'b0;
		last = IW'(cnt_q - CW'(1));
		if (any_same) begin
			unique case (kind_r_q)
				KIND_LOAD: begin
					for (int i = DEPTH - 1; i >= 0; i--) begin
						if (valid_q[i] && !fnd && !lnot) begin
							if (!lp[i]) begin
								lnot = 1'b1;
							end else if (same[i]) begin
								fnd = 1'b1;
								pid = mrg_q[i] ? mst_q[i] : id_q[i];
							end
						end
					end
				end
				KIND_STORE, KIND_NCSTORE: begin
					if (cnt_q != '0 && kind_q[last] == kind_r_q && same[last]
						&& !stt_q[last]) begin
						fnd = 1'b1;
						pid = mrg_q[last] ? mst_q[last] : id_q[last];
					end
				end
				default: begin
					for (int i = DEPTH - 1; i >= 0; i--) begin
						if (same[i] && !fnd) begin
							fnd = 1'b1;
							pid = id_q[i];
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		hit = 1'b0;
		hidx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (idm[i]) begin
				hit = 1'b1;
				hidx = IW'(i);
			end
		end
	end

	assign full = (cnt_q == CW'(DEPTH));

	always_comb begin
		n_next = cnt_q;
		m_next = merged_q;
		unique case (cmd_q)
			CMD_START: if (!full) begin
				n_next = cnt_q + CW'(1);
				if (fnd) m_next = merged_q + CW'(1);
			end
			CMD_FINISH: if (hit) begin
				n_next = cnt_q - CW'(1);
				if (mrg_q[hidx] && merged_q != '0) m_next = merged_q - CW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 4'd6;
			slots_q  <= '0;
			cnt_q    <= '0;
			merged_q <= '0;
			valid_q  <= '0;
			done     <= 1'b0;
		end else begin
			done <= ctrl.apply;
			if (cfg_we) begin
				if (cfg_index == CFG_BLOCK_SHIFT) shift_q <= cfg_data[3:0];
				else slots_q <= cfg_data;
			end
			if (ctrl.apply) begin
				cnt_q <= n_next;
				merged_q <= m_next;
				if (cmd_q == CMD_START && !full) valid_q[cnt_q[IW-1:0]] <= 1'b1;
				if (cmd_q == CMD_FINISH && hit) valid_q[last] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd;
			kind_r_q <= kind;
			aid_q <= access_id;
			addr_q <= address;
		end
		if (ctrl.apply) begin
			if (cmd_q == CMD_START && !full) begin
				id_q[cnt_q[IW-1:0]]   <= aid_q;
				blk_q[cnt_q[IW-1:0]]  <= addr_q;
				kind_q[cnt_q[IW-1:0]] <= kind_r_q;
				mrg_q[cnt_q[IW-1:0]]  <= fnd;
				mst_q[cnt_q[IW-1:0]]  <= pid;
				stt_q[cnt_q[IW-1:0]]  <= 1'b0;
			end
			if (cmd_q == CMD_MARK && hit) stt_q[hidx] <= 1'b1;
			if (cmd_q == CMD_FINISH && hit) begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					if (IW'(i) >= hidx) begin
						id_q[i]   <= id_q[i+1];
						blk_q[i]  <= blk_q[i+1];
						kind_q[i] <= kind_q[i+1];
						mrg_q[i]  <= mrg_q[i+1];
						mst_q[i]  <= mst_q[i+1];
						stt_q[i]  <= stt_q[i+1];
					end
				end
			end
			status <= ST_OK;
			partner_found <= 1'b0;
			partner_id <= '0;
			id_in_flight <= 1'b0;
			unique case (cmd_q)
				CMD_START: begin
					if (full) status <= ST_FULL;
					else begin
						partner_found <= fnd;
						partner_id <= pid;
					end
				end
				CMD_FINISH, CMD_MARK: begin
					if (!hit) status <= ST_NOTFOUND;
					if (cmd_q == CMD_FINISH) id_in_flight <= hit;
				end
				default: begin
					id_in_flight <= hit;
					partner_found <= fnd;
					partner_id <= pid;
				end
			endcase
			occupancy <= n_next;
			may_accept <= (slots_q == '0) || (6'(n_next - m_next) < 6'(slots_q));
		end
	end
endmodule

>>> src/inflight_access_coalescer_top.sv
`timescale 1ns / 1ps
// The result strobe done is registered from the execute state that follows the accepting edge.
// A new request is not taken while busy is high; busy is high for the execute cycle.
// The execute cycle compares all table slots in parallel and updates the table.
// Reset clears the table, the counters and the configuration to their defaults.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// inflight_access_coalescer_top
// In-flight access table with coalescing decisions.
// ----------------------------------------------------------------------------
module inflight_access_coalescer_top #(
	parameter int DEPTH = iac_pkg::DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic [1:0]  cmd,
	input  logic [31:0] access_id,
	input  logic [31:0] address,
	input  logic [1:0]  kind,
	output logic        done,
	output logic [1:0]  status,
	output logic        partner_found,
	output logic [31:0] partner_id,
	output logic        id_in_flight,
	output logic        may_accept,
	output logic [4:0]  occupancy
);
	import iac_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	iac_ctrl_t ctrl;
	logic [CW-1:0] occ;

	iac_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ctrl(ctrl)
	);

	iac_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .access_id(access_id), .address(address), .kind(kind),
		.done(done), .status(status), .partner_found(partner_found),
		.partner_id(partner_id), .id_in_flight(id_in_flight),
		.may_accept(may_accept), .occupancy(occ)
	);

	assign occupancy = 5'(occ);
endmodule

>>> src/iac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_checker
// Port-level checks of the coalescer's request and result timing and of its full status.
// ----------------------------------------------------------------------------
module iac_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic       partner_found
);
	import iac_pkg::*;

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not follow request");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done) else $error("result missing after execute");
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held too long");
	a_full_np: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> !partner_found) else $error("partner on full");
endmodule

bind inflight_access_coalescer_top iac_checker u_iac_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .partner_found(partner_found)
);

>>> test/tb_inflight_access_coalescer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inflight_access_coalescer_top
// Self-checking bench for the in-flight access coalescer.
// A directed table covers the empty table, absent ids, each coalescing rule
// and the extreme ids and addresses. Random requests follow, over several
// block sizes and miss-slot limits. Each result is compared with a behavioral
// copy of the access table in the bench, or with the row's own values for mk_t rows.
// ----------------------------------------------------------------------------
module tb_inflight_access_coalescer_top;
	import iac_pkg::*;

	localparam int SLOTS = 16;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] pid;
		logic        held;
		logic        may;
		logic [4:0]  occ;
	} verdict_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] id;
		logic [31:0] addr;
		logic [1:0]  knd;
		logic        typed;
		verdict_t    want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_we;
	logic        cfg_index;
	logic [4:0]  cfg_data;
	logic [1:0]  cmd;
	logic [31:0] access_id;
	logic [31:0] address;
	logic [1:0]  kind;
	logic        done;
	logic [1:0]  status;
	logic        partner_found;
	logic [31:0] partner_id;
	logic        id_in_flight;
	logic        may_accept;
	logic [4:0]  occupancy;

	inflight_access_coalescer_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .access_id(access_id), .address(address), .kind(kind),
		.done(done), .status(status), .partner_found(partner_found),
		.partner_id(partner_id), .id_in_flight(id_in_flight),
		.may_accept(may_accept), .occupancy(occupancy)
	);

	logic [3:0]  blk_shift;
	logic [4:0]  miss_limit;
	logic [31:0] t_id     [SLOTS];
	logic [31:0] t_addr   [SLOTS];
	logic [1:0]  t_kind   [SLOTS];
	logic        t_merged [SLOTS];
	logic [31:0] t_master [SLOTS];
	logic        t_started[SLOTS];
	int          used;
	int          merged_cnt;

	verdict_t pending_verdicts[$];
	row_t     next_row;
	logic     next_typed;
	int       errors;
	bit       no_gaps;

	function automatic bit same_blk(logic [31:0] a, logic [31:0] b);
		return (a >> blk_shift) == (b >> blk_shift);
	endfunction

	function automatic logic [31:0] master_at(int j);
		return t_merged[j] ? t_master[j] : t_id[j];
	endfunction

	function automatic bit coalesce_target(logic [1:0] k, logic [31:0] a,
			output logic [31:0] pid);
		bit any;
		any = 0;
		pid = '0;
		for (int i = 0; i < used; i++)
			if (same_blk(t_addr[i], a))
				any = 1;
		if (!any)
			return 0;
		if (k == KIND_LOAD) begin
			for (int j = used - 1; j >= 0; j--) begin
				if (t_kind[j] != KIND_LOAD && t_kind[j] != KIND_PREFETCH)
					return 0;
				if (same_blk(t_addr[j], a)) begin
					pid = master_at(j);
					return 1;
				end
			end
			return 0;
		end
		if (k == KIND_STORE || k == KIND_NCSTORE) begin
			if (used == 0 || t_kind[used-1] != k || !same_blk(t_addr[used-1], a)
					|| t_started[used-1])
				return 0;
			pid = master_at(used - 1);
			return 1;
		end
		for (int j = used - 1; j >= 0; j--)
			if (same_blk(t_addr[j], a)) begin
				pid = t_id[j];
				return 1;
			end
		return 0;
	endfunction

	function automatic int slot_of(logic [31:0] id);
		for (int i = 0; i < used; i++)
			if (t_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic verdict_t apply_request(logic [1:0] op, logic [31:0] id,
			logic [31:0] a, logic [1:0] k);
		verdict_t v;
		logic [31:0] pid;
		int s;
		v = '0;
		pid = '0;
		case (op)
			CMD_START: begin
				if (used >= SLOTS) begin
					v.status = ST_FULL;
				end else begin
					v.found = coalesce_target(k, a, pid);
					t_id[used] = id;
					t_addr[used] = a;
					t_kind[used] = k;
					t_merged[used] = v.found;
					t_master[used] = pid;
					t_started[used] = 0;
					if (v.found)
						merged_cnt++;
					used++;
				end
			end
			CMD_FINISH: begin
				s = slot_of(id);
				if (s < 0) begin
					v.status = ST_NOTFOUND;
				end else begin
					v.held = 1;
					if (t_merged[s] && merged_cnt > 0)
						merged_cnt--;
					for (int i = s; i + 1 < used; i++) begin
						t_id[i] = t_id[i+1];
						t_addr[i] = t_addr[i+1];
						t_kind[i] = t_kind[i+1];
						t_merged[i] = t_merged[i+1];
						t_master[i] = t_master[i+1];
						t_started[i] = t_started[i+1];
					end
					used--;
				end
			end
			CMD_MARK: begin
				s = slot_of(id);
				if (s < 0)
					v.status = ST_NOTFOUND;
				else
					t_started[s] = 1;
			end
			default: begin
				v.held = slot_of(id) >= 0;
				v.found = coalesce_target(k, a, pid);
			end
		endcase
		v.pid = v.found ? pid : '0;
		v.may = (miss_limit == 0) || ((used - merged_cnt) < miss_limit);
		v.occ = used[4:0];
		return v;
	endfunction

	function automatic row_t mk(logic [1:0] op, logic [31:0] id, logic [31:0] a,
			logic [1:0] k);
		row_t r;
		r = '0;
		r.op = op;
		r.id = id;
		r.addr = a;
		r.knd = k;
		return r;
	endfunction

	function automatic row_t mk_t(logic [1:0] op, logic [31:0] id, logic [31:0] a,
			logic [1:0] k, logic [1:0] st, logic held, logic [4:0] occ);
		row_t r;
		r = mk(op, id, a, k);
		r.typed = 1;
		r.want.status = st;
		r.want.held = held;
		r.want.may = 1;
		r.want.occ = occ;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		verdict_t w, got;
		if (arst_n) begin
			if (done) begin
				got = '{status, partner_found, partner_id, id_in_flight, may_accept,
					occupancy};
				if (pending_verdicts.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected result: %p", got);
				end else begin
					w = pending_verdicts.pop_front();
					if (got !== w) begin
						errors++;
						if (errors <= 10)
							$display("Mismatch: expected %p, got %p", w, got);
					end
				end
			end
			if (start && !busy) begin
				w = apply_request(cmd, access_id, address, kind);
				if (next_typed)
					w = next_row.want;
				pending_verdicts.push_back(w);
			end
		end
	end

	task automatic send(row_t r);
		while (!no_gaps && $urandom_range(99) < 23) begin
			start = 0;
			@(negedge clk);
		end
		next_row = r;
		next_typed = r.typed;
		cmd = r.op;
		access_id = r.id;
		address = r.addr;
		kind = r.knd;
		start = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [4:0] data);
		start = 0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = data;
		if (idx == CFG_BLOCK_SHIFT)
			blk_shift = data[3:0];
		else
			miss_limit = data;
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic logic [31:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (used > 0 && r < 60)
			return t_id[$urandom_range(used - 1)];
		if (r < 85)
			return $urandom_range(31);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_addr();
		logic [31:0] bases[4] = '{32'h0000_0000, 32'h0000_1000, 32'h8000_0000,
			32'hFFFF_E000};
		if ($urandom_range(99) < 15)
			return $urandom;
		return bases[$urandom_range(3)] + $urandom_range(8191);
	endfunction

	initial begin
		row_t dir[$];
		logic [4:0] shifts[6] = '{5'd6, 5'd2, 5'd12, 5'd0, 5'd31, 5'd4};
		logic [4:0] limits[6] = '{5'd0, 5'd1, 5'd16, 5'd3, 5'd31, 5'd8};
		int total, pct;
		row_t r;
		errors = 0;
		no_gaps = 0;
		next_typed = 0;
		next_row = '0;
		start = 0;
		cfg_we = 0;
		cfg_index = CFG_BLOCK_SHIFT;
		cfg_data = '0;
		cmd = CMD_PROBE;
		access_id = '0;
		address = '0;
		kind = KIND_LOAD;
		blk_shift = 4'd6;
		miss_limit = '0;
		used = 0;
		merged_cnt = 0;
		arst_n = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		dir.push_back(mk_t(CMD_PROBE, 32'd5, 32'h0, KIND_LOAD, ST_OK, 0, 5'd0));
		dir.push_back(mk_t(CMD_FINISH, 32'd5, 32'h0, KIND_LOAD, ST_NOTFOUND, 0, 5'd0));
		dir.push_back(mk_t(CMD_MARK, 32'd5, 32'h0, KIND_LOAD, ST_NOTFOUND, 0, 5'd0));
		dir.push_back(mk_t(CMD_START, 32'd1, 32'h100, KIND_LOAD, ST_OK, 0, 5'd1));
		dir.push_back(mk(CMD_START, 32'd2, 32'h13F, KIND_LOAD));
		dir.push_back(mk(CMD_START, 32'd3, 32'h100, KIND_PREFETCH));
		dir.push_back(mk(CMD_START, 32'd4, 32'h104, KIND_LOAD));
		dir.push_back(mk(CMD_START, 32'd5, 32'h200, KIND_STORE));
		dir.push_back(mk(CMD_START, 32'd6, 32'h208, KIND_STORE));
		dir.push_back(mk(CMD_MARK, 32'd6, 32'h0, KIND_LOAD));
		dir.push_back(mk(CMD_START, 32'd7, 32'h200, KIND_STORE));
		dir.push_back(mk(CMD_START, 32'd8, 32'h200, KIND_NCSTORE));
		dir.push_back(mk(CMD_START, 32'd9, 32'h23C, KIND_NCSTORE));
		dir.push_back(mk(CMD_START, 32'd10, 32'h100, KIND_LOAD));
		dir.push_back(mk(CMD_PROBE, 32'd1, 32'h100, KIND_PREFETCH));
		dir.push_back(mk(CMD_START, 32'd1, 32'h100, KIND_PREFETCH));
		dir.push_back(mk(CMD_FINISH, 32'd1, 32'h0, KIND_LOAD));
		dir.push_back(mk(CMD_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_PREFETCH));
		dir.push_back(mk(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_PREFETCH));
		dir.push_back(mk(CMD_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFC0, KIND_LOAD));
		dir.push_back(mk(CMD_MARK, 32'hFFFF_FFFF, 32'h0, KIND_STORE));
		foreach (dir[i])
			send(dir[i]);

		total = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(CFG_BLOCK_SHIFT, shifts[ph]);
			write_cfg(CFG_MISS_SLOTS, limits[ph]);
			pct = (ph % 2 == 0) ? 55 : 35;
			for (int n = 0; n < 225; n++) begin
				no_gaps = (total >= 400 && total < 600);
				r = '0;
				r.id = pick_id();
				r.addr = pick_addr();
				r.knd = 2'($urandom_range(3));
				if ($urandom_range(99) < pct)
					r.op = CMD_START;
				else
					r.op = 2'($urandom_range(3));
				send(r);
				total++;
			end
		end
		start = 0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
